// ----- rtl/xxhash64_stream_hasher_macros.svh -----
// assertion helpers for the checker file
`ifndef XXHASH64_STREAM_HASHER_MACROS_SVH
`define XXHASH64_STREAM_HASHER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define XXH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define XXH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/xxh_pkg.sv -----
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  // datapath operations
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_H_LOAD    = 4'd1;
  localparam logic [3:0] OP_H_ADDLANE = 4'd2;
  localparam logic [3:0] OP_ROT       = 4'd3;
  localparam logic [3:0] OP_MUL       = 4'd4;
  localparam logic [3:0] OP_G_XOR_H   = 4'd5;
  localparam logic [3:0] OP_G_ADDK    = 4'd6;
  localparam logic [3:0] OP_G_SEED    = 4'd7;
  localparam logic [3:0] OP_G_CONV    = 4'd8;
  localparam logic [3:0] OP_G_ADDLEN  = 4'd9;
  localparam logic [3:0] OP_G_XSHR    = 4'd10;
  localparam logic [3:0] OP_LANE_WR   = 4'd11;
  localparam logic [3:0] OP_BUF_WR    = 4'd12;
  localparam logic [3:0] OP_FIN       = 4'd13;

  // operand register select
  localparam logic SEL_H = 1'b0;
  localparam logic SEL_G = 1'b1;

  // constant select
  localparam logic [2:0] K_P1 = 3'd0;
  localparam logic [2:0] K_P2 = 3'd1;
  localparam logic [2:0] K_P3 = 3'd2;
  localparam logic [2:0] K_P4 = 3'd3;
  localparam logic [2:0] K_P5 = 3'd4;

  // rotate amounts, and right-shift amounts for the avalanche
  localparam logic [1:0] ROT_31 = 2'd0;
  localparam logic [1:0] ROT_27 = 2'd1;
  localparam logic [1:0] ROT_23 = 2'd2;
  localparam logic [1:0] ROT_11 = 2'd3;
  localparam logic [1:0] SHR_33 = 2'd0;
  localparam logic [1:0] SHR_29 = 2'd1;

  // load sources for h
  localparam logic [2:0] SRC_BUF  = 3'd0;
  localparam logic [2:0] SRC_LANE = 3'd1;
  localparam logic [2:0] SRC_WORD = 3'd2;
  localparam logic [2:0] SRC_LO32 = 3'd3;
  localparam logic [2:0] SRC_BYTE = 3'd4;

  typedef struct packed {
    logic       take;
    logic [3:0] op;
    logic       rsel_g;
    logic [2:0] ksel;
    logic [1:0] amt;
    logic [2:0] src;
    logic [2:0] idx;
    logic [3:0] off;
  } xxh_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       round_needed;
    logic       last;
    logic [1:0] fill;
    logic [3:0] cnt;
    logic       long_msg;
    logic       consumed;
    logic       mul_done;
    logic       out_free;
  } xxh_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/xxh_ifs.sv -----
`default_nettype none
interface xxh_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface

interface xxh_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;
  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface
`default_nettype wire

// ----- rtl/xxh_mul.sv -----
`default_nettype none
module xxh_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod
);
  // low 64 bits of a*b from three 32x32 partial products
  logic [1:0]  step_r;
  logic [63:0] acc_r;
  logic [31:0] ma, mb;
  logic [63:0] pp;

  always_comb begin
    case (step_r)
      2'd0: begin ma = a[31:0]; mb = b[31:0]; end
      2'd1: begin ma = a[31:0]; mb = b[63:32]; end
      default: begin ma = a[63:32]; mb = b[31:0]; end
    endcase
  end

  assign pp   = 64'(ma) * 64'(mb);
  assign done = en && (step_r == 2'd2);
  assign prod = acc_r + {pp[31:0], 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
    end else if (!en || done) begin
      step_r <= 2'd0;
    end else begin
      step_r <= step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && step_r == 2'd0) begin
      acc_r <= pp;
    end else if (en && step_r == 2'd1) begin
      acc_r <= prod;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/xxh_dpath.sv -----
`default_nettype none
module xxh_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  xxh_word_if.sink           in_ch,
  xxh_digest_if.source       out_ch,
  xxh_cfg_if.sink            cfg_ch,
  input  wire xxh_pkg::xxh_cmd_t  cmd,
  output xxh_pkg::xxh_stat_t      st
);
  import xxh_pkg::*;

  logic [63:0] seed_r;
  logic [63:0] lane_r [4];
  logic [63:0] buf_r [3];
  logic [1:0]  fill_r;
  logic [63:0] total_r;
  logic        in_msg_r;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        last_r;
  logic        round_r;
  logic        consumed_r;
  logic [63:0] h_r, g_r;
  logic        out_valid_r;
  logic [63:0] digest_r;

  logic        in_acc;
  logic [3:0]  cnt_e;
  logic [63:0] kval, opnd, rot_v, src_v, buf_v, shr_v, mul_p;
  logic        mul_done;

  assign in_acc = in_ch.valid && cmd.take;
  assign in_ch.ready = cmd.take;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.digest = digest_r;

  // short count only counts on the last word, and saturates at eight
  assign cnt_e = (!in_ch.last_word || in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;

  always_comb begin
    case (cmd.ksel)
      K_P1: kval = P1;
      K_P2: kval = P2;
      K_P3: kval = P3;
      K_P4: kval = P4;
      default: kval = P5;
    endcase
    opnd = (cmd.rsel_g == SEL_G) ? g_r : h_r;
    case (cmd.amt)
      ROT_31: rot_v = rotl(opnd, 31);
      ROT_27: rot_v = rotl(opnd, 27);
      ROT_23: rot_v = rotl(opnd, 23);
      default: rot_v = rotl(opnd, 11);
    endcase
    shr_v = (cmd.amt == SHR_33) ? (g_r >> 33) :
            (cmd.amt == SHR_29) ? (g_r >> 29) : (g_r >> 32);
    case (cmd.idx[1:0])
      2'd0: buf_v = buf_r[0];
      2'd1: buf_v = buf_r[1];
      2'd2: buf_v = buf_r[2];
      default: buf_v = word_r;
    endcase
    case (cmd.src)
      SRC_BUF:  src_v = buf_v;
      SRC_LANE: src_v = lane_r[cmd.idx[1:0]];
      SRC_WORD: src_v = word_r;
      SRC_LO32: src_v = {32'b0, word_r[31:0]};
      default:  src_v = {56'b0, 8'(word_r >> {cmd.off[2:0], 3'b000})};
    endcase
  end

  xxh_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (cmd.op == OP_MUL),
    .a    (opnd),
    .b    (kval),
    .done (mul_done),
    .prod (mul_p)
  );

  always_comb begin
    st.in_valid     = in_ch.valid;
    st.round_needed = round_r;
    st.last         = last_r;
    st.fill         = fill_r;
    st.cnt          = cnt_r;
    st.long_msg     = (total_r[63:5] != 59'd0);
    st.consumed     = consumed_r;
    st.mul_done     = mul_done;
    st.out_free     = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'd0;
    end else if (cfg_ch.valid) begin
      seed_r <= cfg_ch.seed;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r    <= 1'b0;
      fill_r      <= 2'd0;
      total_r     <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        in_msg_r <= 1'b1;
        total_r  <= (in_msg_r ? total_r : 64'd0) + 64'(cnt_e);
        if (!in_msg_r) begin
          fill_r <= 2'd0;
        end
      end
      case (cmd.op)
        OP_BUF_WR: fill_r <= fill_r + 2'd1;
        OP_LANE_WR: begin
          if (cmd.idx[1:0] == 2'd3) begin
            fill_r <= 2'd0;
          end
        end
        OP_FIN: begin
          fill_r   <= 2'd0;
          in_msg_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r     <= in_ch.data_word;
      cnt_r      <= cnt_e;
      last_r     <= in_ch.last_word;
      round_r    <= (cnt_e == 4'd8) && in_msg_r && (fill_r == 2'd3);
      consumed_r <= 1'b0;
      if (!in_msg_r) begin
        lane_r[0] <= seed_r + P1 + P2;
        lane_r[1] <= seed_r + P2;
        lane_r[2] <= seed_r;
        lane_r[3] <= seed_r - P1;
      end
    end
    case (cmd.op)
      OP_H_LOAD:    h_r <= src_v;
      OP_H_ADDLANE: h_r <= h_r + lane_r[cmd.idx[1:0]];
      OP_ROT: begin
        if (cmd.rsel_g == SEL_G) g_r <= rot_v;
        else h_r <= rot_v;
      end
      OP_MUL: begin
        if (mul_done) begin
          if (cmd.rsel_g == SEL_G) g_r <= mul_p;
          else h_r <= mul_p;
        end
      end
      OP_G_XOR_H:  g_r <= g_r ^ h_r;
      OP_G_ADDK:   g_r <= g_r + kval;
      OP_G_SEED:   g_r <= seed_r + P5;
      OP_G_CONV:   g_r <= rotl(lane_r[0], 1) + rotl(lane_r[1], 7) +
                          rotl(lane_r[2], 12) + rotl(lane_r[3], 18);
      OP_G_ADDLEN: g_r <= g_r + total_r;
      OP_G_XSHR:   g_r <= g_r ^ shr_v;
      OP_LANE_WR: begin
        lane_r[cmd.idx[1:0]] <= h_r;
        if (cmd.idx[1:0] == 2'd3) consumed_r <= 1'b1;
      end
      OP_BUF_WR:   buf_r[fill_r] <= word_r;
      OP_FIN:      digest_r <= g_r ^ (g_r >> 32);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/xxh_ctrl.sv -----
`default_nettype none
module xxh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire xxh_pkg::xxh_stat_t st,
  output xxh_pkg::xxh_cmd_t       cmd
);
  import xxh_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0, S_DISP = 6'd1, S_R_LOAD = 6'd2, S_R_M1 = 6'd3,
    S_R_ADD = 6'd4, S_R_ROT = 6'd5, S_R_M2 = 6'd6, S_R_END = 6'd7, S_M_MUL = 6'd8,
    S_M_ADD = 6'd9, S_T_ROT = 6'd10, S_T_MUL = 6'd11, S_T_ADD = 6'd12, S_F_START = 6'd13,
    S_F_LEN = 6'd14, S_F_WORD = 6'd15, S_Q_LOAD = 6'd16, S_Q_M1 = 6'd17, S_Q_XOR = 6'd18,
    S_Q_ROT = 6'd19, S_Q_M2 = 6'd20, S_Q_ADD = 6'd21, S_B_CHK = 6'd22, S_B_LOAD = 6'd23,
    S_B_M1 = 6'd24, S_B_XOR = 6'd25, S_B_ROT = 6'd26, S_B_M2 = 6'd27, S_AV1 = 6'd28,
    S_AV2 = 6'd29, S_AV3 = 6'd30, S_AV4 = 6'd31, S_FIN = 6'd32;

  localparam logic [1:0] M_LANE = 2'd0, M_MERGE = 2'd1, M_TAIL = 2'd2;

  logic [5:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [3:0] off_r, off_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       wtail_r, wtail_nxt;

  always_comb begin
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.off   = off_r;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    off_nxt   = off_r;
    mode_nxt  = mode_r;
    wtail_nxt = wtail_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (st.in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        idx_nxt = 3'd0;
        if (st.round_needed) begin
          mode_nxt  = M_LANE;
          state_nxt = S_R_LOAD;
        end else if (!st.last) begin
          cmd.op    = OP_BUF_WR;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_F_START;
        end
      end
      S_R_LOAD: begin
        cmd.op = OP_H_LOAD;
        case (mode_r)
          M_LANE:  cmd.src = (idx_r == 3'd3) ? SRC_WORD : SRC_BUF;
          M_MERGE: cmd.src = SRC_LANE;
          default: cmd.src = wtail_r ? SRC_WORD : SRC_BUF;
        endcase
        state_nxt = S_R_M1;
      end
      S_R_M1: begin
        cmd.op = OP_MUL; cmd.ksel = K_P2;
        if (st.mul_done) state_nxt = S_R_ADD;
      end
      S_R_ADD: begin
        cmd.op    = (mode_r == M_LANE) ? OP_H_ADDLANE : OP_NOP;
        state_nxt = S_R_ROT;
      end
      S_R_ROT: begin
        cmd.op = OP_ROT; cmd.amt = ROT_31;
        state_nxt = S_R_M2;
      end
      S_R_M2: begin
        cmd.op = OP_MUL; cmd.ksel = K_P1;
        if (st.mul_done) state_nxt = S_R_END;
      end
      S_R_END: begin
        if (mode_r == M_LANE) begin
          cmd.op  = OP_LANE_WR;
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd3) state_nxt = st.last ? S_F_START : S_IDLE;
          else state_nxt = S_R_LOAD;
        end else begin
          cmd.op    = OP_G_XOR_H;
          state_nxt = (mode_r == M_MERGE) ? S_M_MUL : S_T_ROT;
        end
      end
      S_M_MUL: begin
        cmd.op = OP_MUL; cmd.rsel_g = SEL_G; cmd.ksel = K_P1;
        if (st.mul_done) state_nxt = S_M_ADD;
      end
      S_M_ADD: begin
        cmd.op = OP_G_ADDK; cmd.ksel = K_P4;
        idx_nxt   = idx_r + 3'd1;
        state_nxt = (idx_r == 3'd3) ? S_F_LEN : S_R_LOAD;
      end
      S_T_ROT: begin
        cmd.op = OP_ROT; cmd.rsel_g = SEL_G; cmd.amt = ROT_27;
        state_nxt = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.op = OP_MUL; cmd.rsel_g = SEL_G; cmd.ksel = K_P1;
        if (st.mul_done) state_nxt = S_T_ADD;
      end
      S_T_ADD: begin
        cmd.op = OP_G_ADDK; cmd.ksel = K_P4;
        idx_nxt = idx_r + 3'd1;
        if (wtail_r) state_nxt = S_AV1;
        else if (idx_nxt == {1'b0, st.fill}) state_nxt = S_F_WORD;
        else state_nxt = S_R_LOAD;
      end
      S_F_START: begin
        idx_nxt = 3'd0;
        if (st.long_msg) begin
          cmd.op    = OP_G_CONV;
          mode_nxt  = M_MERGE;
          state_nxt = S_R_LOAD;
        end else begin
          cmd.op    = OP_G_SEED;
          state_nxt = S_F_LEN;
        end
      end
      S_F_LEN: begin
        cmd.op    = OP_G_ADDLEN;
        idx_nxt   = 3'd0;
        mode_nxt  = M_TAIL;
        wtail_nxt = 1'b0;
        state_nxt = (st.fill != 2'd0) ? S_R_LOAD : S_F_WORD;
      end
      S_F_WORD: begin
        if (st.consumed) begin
          state_nxt = S_AV1;
        end else if (st.cnt == 4'd8) begin
          wtail_nxt = 1'b1;
          mode_nxt  = M_TAIL;
          state_nxt = S_R_LOAD;
        end else if (st.cnt >= 4'd4) begin
          state_nxt = S_Q_LOAD;
        end else begin
          off_nxt   = 4'd0;
          state_nxt = S_B_CHK;
        end
      end
      S_Q_LOAD: begin
        cmd.op = OP_H_LOAD; cmd.src = SRC_LO32;
        state_nxt = S_Q_M1;
      end
      S_Q_M1: begin
        cmd.op = OP_MUL; cmd.ksel = K_P1;
        if (st.mul_done) state_nxt = S_Q_XOR;
      end
      S_Q_XOR: begin
        cmd.op = OP_G_XOR_H;
        state_nxt = S_Q_ROT;
      end
      S_Q_ROT: begin
        cmd.op = OP_ROT; cmd.rsel_g = SEL_G; cmd.amt = ROT_23;
        state_nxt = S_Q_M2;
      end
      S_Q_M2: begin
        cmd.op = OP_MUL; cmd.rsel_g = SEL_G; cmd.ksel = K_P2;
        if (st.mul_done) state_nxt = S_Q_ADD;
      end
      S_Q_ADD: begin
        cmd.op = OP_G_ADDK; cmd.ksel = K_P3;
        off_nxt   = 4'd4;
        state_nxt = S_B_CHK;
      end
      S_B_CHK: begin
        state_nxt = (off_r < st.cnt) ? S_B_LOAD : S_AV1;
      end
      S_B_LOAD: begin
        cmd.op = OP_H_LOAD; cmd.src = SRC_BYTE;
        state_nxt = S_B_M1;
      end
      S_B_M1: begin
        cmd.op = OP_MUL; cmd.ksel = K_P5;
        if (st.mul_done) state_nxt = S_B_XOR;
      end
      S_B_XOR: begin
        cmd.op = OP_G_XOR_H;
        state_nxt = S_B_ROT;
      end
      S_B_ROT: begin
        cmd.op = OP_ROT; cmd.rsel_g = SEL_G; cmd.amt = ROT_11;
        state_nxt = S_B_M2;
      end
      S_B_M2: begin
        cmd.op = OP_MUL; cmd.rsel_g = SEL_G; cmd.ksel = K_P1;
        if (st.mul_done) begin
          off_nxt   = off_r + 4'd1;
          state_nxt = S_B_CHK;
        end
      end
      S_AV1: begin
        cmd.op = OP_G_XSHR; cmd.amt = SHR_33;
        state_nxt = S_AV2;
      end
      S_AV2: begin
        cmd.op = OP_MUL; cmd.rsel_g = SEL_G; cmd.ksel = K_P2;
        if (st.mul_done) state_nxt = S_AV3;
      end
      S_AV3: begin
        cmd.op = OP_G_XSHR; cmd.amt = SHR_29;
        state_nxt = S_AV4;
      end
      S_AV4: begin
        cmd.op = OP_MUL; cmd.rsel_g = SEL_G; cmd.ksel = K_P3;
        if (st.mul_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 3'd0;
      off_r   <= 4'd0;
      mode_r  <= M_LANE;
      wtail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      off_r   <= off_nxt;
      mode_r  <= mode_nxt;
      wtail_r <= wtail_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/xxhash64_stream_hasher.sv -----
// xxh64 stream hasher
// in_ch: one message word per handshake (valid/ready): 64 data bits little-endian,
//   byte count, last marker; every word before the last is taken as eight bytes
// cfg_ch: seed write, always ready; write only while no message is open
// out_ch: one 64-bit digest per message, held in an output register until taken
// timing: all 64-bit multiplies run on one 32x32 multiplier, 3 cycles each
//   word that only fills the stripe buffer: 2 cycles
//   word that closes a 32-byte stripe: 42 cycles (four lane rounds, two multiplies each)
//   last word adds finalization: lane merge 57 cycles for messages of 32 bytes
//   or more, 15 cycles per buffered or full tail word, 10 for a 4-byte
//   step, 10 per single tail byte, and 9 for the avalanche and digest write
// the next message word is taken while a digest still waits in the output register
// a stalled receiver holds the block only at the end of the next message
// reset: synchronous active-low rst_n clears the open message, seed and output valid
`default_nettype none
module xxhash64_stream_hasher (
  input  wire logic     clk,
  input  wire logic     rst_n,
  xxh_word_if.sink      in_ch,
  xxh_digest_if.source  out_ch,
  xxh_cfg_if.sink       cfg_ch
);
  import xxh_pkg::*;

  xxh_cmd_t  cmd;
  xxh_stat_t st;

  // sequencer: decides which datapath step runs each cycle
  xxh_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .cmd  (cmd)
  );

  // lanes, stripe buffer, length, hash registers and shared multiplier
  xxh_dpath u_dpath (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch),
    .cmd   (cmd),
    .st    (st)
  );
endmodule
`default_nettype wire

// ----- rtl/xxh_chk.sv -----
`default_nettype none
`include "xxhash64_stream_hasher_macros.svh"
module xxh_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] digest,
  input wire logic        cfg_ready
);
  `XXH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "digest dropped")
  `XXH_ASSERT_NEXT(a_dig_stable, out_valid && !out_ready, $stable(digest), "digest moved")
  `XXH_ASSERT_NEXT(a_word_busy, in_valid && in_ready, !in_ready, "ready after word")
  `XXH_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "seed port stalled")
endmodule

bind xxhash64_stream_hasher xxh_chk u_xxh_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .digest   (out_ch.digest),
  .cfg_ready(cfg_ch.ready)
);
`default_nettype wire

// ----- bench/xxh_hash_board.sv -----
`timescale 1ns / 100ps
// expected digests of finished messages, checked in order
package xxh_hash_board_pkg;
  import xxh_pkg::*;

  class xxh_hash_board;
    logic [63:0] seed_val;
    logic [63:0] lane[4];
    logic [63:0] stripe[3];
    int unsigned fill;
    logic [63:0] msg_len;
    bit          open_msg;
    logic [63:0] digest_q[$];
    int unsigned mismatches;

    function new();
      seed_val = '0;
      fill = 0;
      msg_len = '0;
      open_msg = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] rol(logic [63:0] x, int unsigned r);
      return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
    endfunction

    function logic [63:0] lane_round(logic [63:0] acc, logic [63:0] w);
      acc = acc + w * P2;
      return rol(acc, 31) * P1;
    endfunction

    function logic [63:0] fold_eight(logic [63:0] h, logic [63:0] w);
      h = h ^ lane_round('0, w);
      return rol(h, 27) * P1 + P4;
    endfunction

    function void set_seed(logic [63:0] s);
      seed_val = s;
    endfunction

    // note an accepted word; a last word queues its digest
    function void note_word(logic [63:0] w, logic [3:0] cnt_in, bit last);
      int unsigned cnt;
      int unsigned off;
      bit used;
      logic [63:0] h;
      used = 0;
      if (!open_msg) begin
        lane[0] = seed_val + P1 + P2;
        lane[1] = seed_val + P2;
        lane[2] = seed_val;
        lane[3] = seed_val - P1;
        fill = 0;
        msg_len = '0;
        open_msg = 1;
      end
      cnt = (!last || cnt_in > 8) ? 8 : cnt_in;
      msg_len = msg_len + cnt;
      if (cnt == 8 && fill == 3) begin
        for (int i = 0; i < 3; i++) lane[i] = lane_round(lane[i], stripe[i]);
        lane[3] = lane_round(lane[3], w);
        fill = 0;
        used = 1;
      end else if (!last && fill < 3) begin
        stripe[fill] = w;
        fill++;
      end
      if (!last) return;
      if (msg_len >= 32) begin
        h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
        for (int i = 0; i < 4; i++) h = (h ^ lane_round('0, lane[i])) * P1 + P4;
      end else begin
        h = seed_val + P5;
      end
      h = h + msg_len;
      for (int i = 0; i < fill; i++) h = fold_eight(h, stripe[i]);
      if (!used) begin
        if (cnt == 8) begin
          h = fold_eight(h, w);
        end else begin
          off = 0;
          if (cnt >= 4) begin
            h = h ^ ({32'd0, w[31:0]} * P1);
            h = rol(h, 23) * P2 + P3;
            off = 4;
          end
          for (; off < cnt; off++) begin
            h = h ^ ({56'd0, w[8*off +: 8]} * P5);
            h = rol(h, 11) * P1;
          end
        end
      end
      h = h ^ (h >> 33);
      h = h * P2;
      h = h ^ (h >> 29);
      h = h * P3;
      h = h ^ (h >> 32);
      fill = 0;
      open_msg = 0;
      digest_q.push_back(h);
    endfunction

    function void check_digest(logic [63:0] got);
      logic [63:0] want;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest %h", got);
        return;
      end
      want = digest_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("digest mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass
endpackage

// ----- bench/tb_xxhash64_stream_hasher.sv -----
`timescale 1ns / 100ps
module tb_xxhash64_stream_hasher;
  import xxh_pkg::*;
  import xxh_hash_board_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  xxh_word_if   in_ch();
  xxh_digest_if out_ch();
  xxh_cfg_if    cfg_ch();

  xxhash64_stream_hasher i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  xxh_hash_board board = new();
  int unsigned cycle_count = 0;
  bit words_done = 0;
  bit drain_on = 0;

  // cycle counter; limit covers slow finalization on every message with full stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random ready stalls, sampled at the rising edge
  initial begin
    int unsigned gap;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      gap = drain_on ? 0 : $urandom_range(0, 3);
      repeat (gap) @(negedge clk);
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_digest(out_ch.digest);
      @(negedge clk);
      out_ch.ready <= 0;
    end
  end

  // send one word, waiting a random gap first unless no_gap is set; the word is noted on acceptance
  task automatic send_word(logic [63:0] w, logic [3:0] cnt, bit last, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1;
    in_ch.data_word  <= w;
    in_ch.byte_count <= cnt;
    in_ch.last_word  <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(w, cnt, last);
    @(negedge clk);
  endtask

  task automatic idle_in();
    in_ch.valid <= 0;
  endtask

  // seed write only with no message open and nothing pending
  task automatic write_seed(logic [63:0] s);
    idle_in();
    wait (board.digest_q.size() == 0);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.seed  <= s;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_seed(s);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one message: nwords full words then a last word with given count
  task automatic send_message(int unsigned nwords, logic [3:0] last_cnt, bit burst);
    for (int i = 0; i < nwords; i++)
      // a short count before the last word is treated as full
      send_word(rand64(), ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
                0, burst);
    send_word(rand64(), last_cnt, 1, burst);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    in_ch.valid = 0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.last_word = 0;
    cfg_ch.valid = 0;
    cfg_ch.seed = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty, byte counts 0..15, stripe edges, extreme data
    send_word('0, 4'd0, 1, 0);
    for (int c = 1; c <= 15; c++) send_word(rand64(), 4'(c), 1, 0);
    send_word('1, 4'd8, 1, 0);
    send_message(3, 4'd8, 0);
    send_message(3, 4'd5, 0);
    send_message(4, 4'd0, 0);
    write_seed('1);
    send_message(7, 4'd8, 1);
    send_word('1, 4'd7, 1, 0);
    write_seed(64'h8000_0000_0000_0001);
    send_message(4, 4'd3, 0);
    // seed change between messages only; hold through the tail of finalization
    idle_in();
    repeat (300) @(posedge clk);

    sent = 44;
    while (sent < 400) begin
      if ($urandom_range(0, 9) == 0) begin
        write_seed(($urandom_range(0, 3) == 0) ? '0 : rand64());
      end
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
      send_message(n, 4'($urandom_range(0, 15)), $urandom_range(0, 4) == 0);
      sent += n + 1;
    end
    idle_in();
    drain_on = 1;
    wait (board.digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (board.mismatches == 0 && board.digest_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/xxh_pkg.sv
rtl/xxh_ifs.sv
rtl/xxh_mul.sv
rtl/xxh_dpath.sv
rtl/xxh_ctrl.sv
rtl/xxhash64_stream_hasher.sv
rtl/xxh_chk.sv
bench/xxh_hash_board.sv
bench/tb_xxhash64_stream_hasher.sv
